// File: sv/s5rp_pkg.sv
// Package for the SOCKS5 request parser: payload structs and protocol codes.
// No dependencies; every module of the block imports it.
`default_nettype none
package s5rp_pkg;

  // Protocol bytes and field lengths.
  localparam logic [7:0] VERSION_BYTE  = 8'd5;
  localparam logic [7:0] RESERVED_BYTE = 8'h00;
  localparam logic [7:0] ATYP_IPV4     = 8'd1;
  localparam logic [7:0] ATYP_DOMAIN   = 8'd3;
  localparam logic [7:0] ATYP_IPV6     = 8'd4;
  localparam logic [7:0] IPV4_LEN      = 8'd4;
  localparam logic [7:0] IPV6_LEN      = 8'd16;
  localparam logic [7:0] PORT_LEN      = 8'd2;

  // Status codes.
  localparam logic [1:0] ST_PARSING  = 2'd0;
  localparam logic [1:0] ST_COMPLETE = 2'd1;
  localparam logic [1:0] ST_REJECT   = 2'd2;
  localparam logic [1:0] ST_IGNORED  = 2'd3;

  // Error codes.
  localparam logic [1:0] ER_VERSION  = 2'd0;
  localparam logic [1:0] ER_RESERVED = 2'd1;
  localparam logic [1:0] ER_TYPE     = 2'd2;
  localparam logic [1:0] ER_SHORT    = 2'd3;

  // Byte role tags.
  localparam logic [2:0] ROLE_VERSION  = 3'd0;
  localparam logic [2:0] ROLE_COMMAND  = 3'd1;
  localparam logic [2:0] ROLE_RESERVED = 3'd2;
  localparam logic [2:0] ROLE_TYPE     = 3'd3;
  localparam logic [2:0] ROLE_DLEN     = 3'd4;
  localparam logic [2:0] ROLE_ADDRESS  = 3'd5;
  localparam logic [2:0] ROLE_PORT     = 3'd6;
  localparam logic [2:0] ROLE_TRAILING = 3'd7;

  // One incoming byte of the request buffer.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_of_buffer;
  } in_t;

  // One result per byte.
  typedef struct packed {
    logic [1:0]  status;
    logic [1:0]  error_code;
    logic [2:0]  byte_role;
    logic [7:0]  address_index;
    logic [7:0]  command;
    logic [7:0]  address_type;
    logic [15:0] port;
    logic [8:0]  consumed;
  } out_t;

endpackage
`default_nettype wire

// File: sv/s5rp_in_reg.sv
// Input register of the SOCKS5 request parser: holds one byte ahead of the parser.
// Depends on s5rp_pkg for the input struct.
`default_nettype none
module s5rp_in_reg (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire s5rp_pkg::in_t in_data,
  output logic               hold_valid,
  input  wire logic          hold_take,
  output s5rp_pkg::in_t      hold_data
);
  import s5rp_pkg::*;

  logic valid_r;
  in_t  data_r;

  // The register can load when empty or when its byte moves on this cycle.
  assign in_ready   = !valid_r || hold_take;
  assign hold_valid = valid_r;
  assign hold_data  = data_r;

  // Valid flag and payload.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data_r <= in_data;
    end
  end

endmodule
`default_nettype wire

// File: sv/s5rp_core.sv
// Per-byte parser state machine of the SOCKS5 request parser.
// Decodes one byte against the held state; state updates when step is high. Uses s5rp_pkg.
`default_nettype none
module s5rp_core (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          step,
  input  wire s5rp_pkg::in_t item,
  output s5rp_pkg::out_t     result
);
  import s5rp_pkg::*;

  typedef enum logic [2:0] {
    PH_VER, PH_CMD, PH_RSV, PH_ATYP, PH_DLEN, PH_ADDR, PH_PORT, PH_IGNORE
  } phase_t;

  phase_t      phase_r, phase_nxt, phase_pre;
  logic [8:0]  pos_r, pos_nxt;
  logic [7:0]  fcnt_r, fcnt_nxt;
  logic [7:0]  dlen_r, dlen_nxt;
  logic [7:0]  cmd_r, cmd_nxt;
  logic [7:0]  atyp_r, atyp_nxt;
  logic [15:0] port_r, port_nxt;

  logic        err;
  logic [1:0]  err_code;
  logic [1:0]  status;
  logic [7:0]  fcnt_inc;
  logic [7:0]  addr_total;
  logic [7:0]  b;
  logic        pos_inc;

  assign b        = item.data_byte;
  assign fcnt_inc = fcnt_r + 8'd1;

  // Address length follows the held address type.
  always_comb begin
    if (atyp_r == ATYP_IPV4) begin
      addr_total = IPV4_LEN;
    end else if (atyp_r == ATYP_IPV6) begin
      addr_total = IPV6_LEN;
    end else begin
      addr_total = dlen_r;
    end
  end

  // Decode of the current byte and next state.
  always_comb begin
    phase_pre = phase_r;
    fcnt_nxt  = fcnt_r;
    dlen_nxt  = dlen_r;
    cmd_nxt   = cmd_r;
    atyp_nxt  = atyp_r;
    port_nxt  = port_r;
    pos_nxt   = pos_r;
    err       = 1'b0;
    err_code  = ER_VERSION;
    status    = ST_PARSING;
    result    = '0;
    result.byte_role = ROLE_TRAILING;

    unique case (phase_r)
      PH_VER: begin
        result.byte_role = ROLE_VERSION;
        if (b != VERSION_BYTE) begin
          err      = 1'b1;
          err_code = ER_VERSION;
        end else begin
          phase_pre = PH_CMD;
        end
      end
      PH_CMD: begin
        result.byte_role = ROLE_COMMAND;
        cmd_nxt   = b;
        phase_pre = PH_RSV;
      end
      PH_RSV: begin
        result.byte_role = ROLE_RESERVED;
        if (b != RESERVED_BYTE) begin
          err      = 1'b1;
          err_code = ER_RESERVED;
        end else begin
          phase_pre = PH_ATYP;
        end
      end
      PH_ATYP: begin
        result.byte_role = ROLE_TYPE;
        atyp_nxt = b;
        fcnt_nxt = '0;
        if (b == ATYP_IPV4 || b == ATYP_IPV6) begin
          phase_pre = PH_ADDR;
        end else if (b == ATYP_DOMAIN) begin
          phase_pre = PH_DLEN;
        end else begin
          err      = 1'b1;
          err_code = ER_TYPE;
        end
      end
      PH_DLEN: begin
        result.byte_role = ROLE_DLEN;
        dlen_nxt  = b;
        fcnt_nxt  = '0;
        phase_pre = (b == 8'd0) ? PH_PORT : PH_ADDR;
      end
      PH_ADDR: begin
        result.byte_role     = ROLE_ADDRESS;
        result.address_index = fcnt_r;
        if (fcnt_inc >= addr_total) begin
          fcnt_nxt  = '0;
          phase_pre = PH_PORT;
        end else begin
          fcnt_nxt = fcnt_inc;
        end
      end
      PH_PORT: begin
        result.byte_role = ROLE_PORT;
        port_nxt = {port_r[7:0], b};
        fcnt_nxt = fcnt_inc;
        if (fcnt_inc >= PORT_LEN) begin
          status              = ST_COMPLETE;
          result.command      = cmd_r;
          result.address_type = atyp_r;
          result.port         = {port_r[7:0], b};
          result.consumed     = pos_r + 9'd1;
          phase_pre           = PH_IGNORE;
        end
      end
      default: begin
        status = ST_IGNORED;
      end
    endcase

    // The request length counts every byte up to and including the final one.
    pos_inc = (phase_pre != PH_IGNORE) || (status == ST_COMPLETE);
    if (pos_inc && (pos_r != 9'h1FF)) begin
      pos_nxt = pos_r + 9'd1;
    end

    // Content errors win over a buffer that ends early.
    phase_nxt = phase_pre;
    if (err) begin
      status    = ST_REJECT;
      phase_nxt = PH_IGNORE;
    end else if (item.last_of_buffer && (status == ST_PARSING)) begin
      status   = ST_REJECT;
      err_code = ER_SHORT;
    end

    result.status     = status;
    result.error_code = (status == ST_REJECT) ? err_code : ER_VERSION;
  end

  // Parser state; the last byte of a buffer returns it to the start.
  always_ff @(posedge clk) begin
    if (!rst_n || (step && item.last_of_buffer)) begin
      phase_r <= PH_VER;
      pos_r   <= '0;
      fcnt_r  <= '0;
      dlen_r  <= '0;
      cmd_r   <= '0;
      atyp_r  <= '0;
      port_r  <= '0;
    end else if (step) begin
      phase_r <= phase_nxt;
      pos_r   <= pos_nxt;
      fcnt_r  <= fcnt_nxt;
      dlen_r  <= dlen_nxt;
      cmd_r   <= cmd_nxt;
      atyp_r  <= atyp_nxt;
      port_r  <= port_nxt;
    end
  end

endmodule
`default_nettype wire

// File: sv/s5rp_out_reg.sv
// Result register of the SOCKS5 request parser: holds one result for the receiver.
// Depends on s5rp_pkg for the result struct.
`default_nettype none
module s5rp_out_reg (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           res_valid,
  output logic                res_take,
  input  wire s5rp_pkg::out_t res_data,
  output logic                out_valid,
  input  wire logic           out_ready,
  output s5rp_pkg::out_t      out_data
);
  import s5rp_pkg::*;

  logic valid_r;
  out_t data_r;

  // A new result loads when the register is empty or is being read out.
  assign res_take  = res_valid && (!valid_r || out_ready);
  assign out_valid = valid_r;
  assign out_data  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (!valid_r || out_ready) begin
      valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      data_r <= res_data;
    end
  end

endmodule
`default_nettype wire

// File: sv/socks5_request_parser_top.sv
// Top level of the SOCKS5 request parser.
// Instantiates s5rp_in_reg, s5rp_core and s5rp_out_reg; uses s5rp_pkg.
//
// Usage:
//   in_valid/in_ready/in_data carry one byte of the request buffer per request,
//   with last_of_buffer set on the final byte. out_valid/out_ready/out_data carry
//   one result per byte: status, error code, role tag, address index and, on
//   completion, command, address type, port and consumed length.
//   A byte accepted into the input register is decoded by s5rp_core and its
//   result is loaded into the result register, which drives out_valid.
//   Throughput: one byte per cycle while out_ready is high, limited by the
//   single state update in s5rp_core.
//   Reset (rst_n low, synchronous) empties both registers and puts the parser
//   back to expecting the version byte.
//   When the receiver holds out_ready low, the result register keeps its
//   result, the input register takes one more byte only if it is empty, and
//   in_ready stays low while it is full, until the result is taken.
`default_nettype none
module socks5_request_parser_top (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire s5rp_pkg::in_t  in_data,
  output logic                out_valid,
  input  wire logic           out_ready,
  output s5rp_pkg::out_t      out_data
);
  import s5rp_pkg::*;

  logic hold_valid;
  logic hold_take;
  in_t  hold_data;
  out_t res_data;

  // Byte held ahead of the parser.
  s5rp_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .hold_valid (hold_valid),
    .hold_take  (hold_take),
    .hold_data  (hold_data)
  );

  // Parser state advances when the byte moves into the result register.
  s5rp_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (hold_take),
    .item   (hold_data),
    .result (res_data)
  );

  // Result register toward the receiver.
  s5rp_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (hold_valid),
    .res_take  (hold_take),
    .res_data  (res_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire
